FILE: hdl/ebas_pkg.sv
// Shared constants and codes for the escaped byte array store.
`timescale 1ns / 1ps
`default_nettype none
package ebas_pkg;
    localparam int ENTRIES_DEF    = 65536;
    localparam int OVF_DEPTH_DEF  = 4096;
    localparam int AL_W           = 17;
    localparam int AL_RESET       = 65536;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [7:0] ESCAPE_BYTE = 8'd255;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic REG_ARRAY_LENGTH = 1'b0;
endpackage
`default_nettype wire

FILE: hdl/ebas_cfg.sv
// Configuration register file with the saturated effective array length.
`timescale 1ns / 1ps
`default_nettype none
module ebas_cfg #(
    parameter int ENTRIES = ebas_pkg::ENTRIES_DEF,
    parameter int EL_W    = 17
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ebas_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ebas_pkg::PDATA_W-1:0] pwdata,
    output logic      [ebas_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output logic      [EL_W-1:0]              o_eff_len
);
    import ebas_pkg::*;

    logic [AL_W-1:0] r_array_length;
    logic [EL_W-1:0] al_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_array_length <= AL_W'(AL_RESET);
        end else if (psel && penable && pwrite && pready
                     && paddr[PADDR_W-1] == REG_ARRAY_LENGTH) begin
            r_array_length <= pwdata[AL_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_ARRAY_LENGTH) ?
                    PDATA_W'(r_array_length) : '0;

    assign al_ext = EL_W'(r_array_length);

    always_comb begin
        if (al_ext == '0) begin
            o_eff_len = EL_W'(1);
        end else if (al_ext > EL_W'(ENTRIES)) begin
            o_eff_len = EL_W'(ENTRIES);
        end else begin
            o_eff_len = al_ext;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/escaped_byte_array_store.sv
// Top level of the escaped byte array store with its byte store and overflow table.
`timescale 1ns / 1ps
`default_nettype none
// Usage: a request is taken when start is high and busy is low. A load request
// (operation 0) writes load_value at the next index; a read request (operation 1)
// returns the value at read_index. Every request yields one result on o_read_data
// and o_status, shown for exactly one cycle while o_done is high; the receiver
// cannot stall, so nothing is held back.
// A load's result appears the cycle after acceptance, and busy stays low, so
// loads may arrive every cycle.
// A plain byte read passes through S_BYTE. An escaped read adds a probe of the
// overflow table at the advanced cursor (S_CURSOR), and on a miss a lower-bound
// binary search with one table read per probe (S_SEARCH), then one more read for
// the found value (S_FINAL), one after another on the table's single read port.
// Reset clears the counters, the cursor and the ready flag, and sets array_length
// to 65536; the memories are not cleared, and reads of unwritten bytes are not
// blocked. array_length is written over the APB port at byte address 0 while
// idle, a rule on the user that the block itself does not enforce.
module escaped_byte_array_store #(
    parameter int ENTRIES        = ebas_pkg::ENTRIES_DEF,
    parameter int OVERFLOW_DEPTH = ebas_pkg::OVF_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_operation,
    input  wire logic [15:0]                  i_read_index,
    input  wire logic [31:0]                  i_load_value,
    output logic                              o_done,
    output logic      [31:0]                  o_read_data,
    output logic      [1:0]                   o_status,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ebas_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ebas_pkg::PDATA_W-1:0] pwdata,
    output logic      [ebas_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);
    import ebas_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int LEN_W  = $clog2(ENTRIES + 1);
    localparam int EL_W   = (LEN_W > AL_W) ? LEN_W : AL_W;
    localparam int CMP_W  = (IDX_W > 16) ? IDX_W : 16;
    localparam int SLOT_W = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(OVERFLOW_DEPTH + 1);
    localparam int TB_W   = IDX_W + 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_CURSOR,
        S_SEARCH,
        S_FINAL
    } t_state;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_lc, n_lc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_cursor, n_cursor;
    logic              r_ready, n_ready;
    logic [CMP_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_lo, n_lo;
    logic [CNT_W-1:0]  r_hi, n_hi;
    logic              r_done, n_done;
    logic [31:0]       r_data, n_data;
    logic [1:0]        r_status, n_status;

    logic [EL_W-1:0]   eff_len;

    logic [7:0]        byte_mem [ENTRIES];
    logic [TB_W-1:0]   tb_mem [OVERFLOW_DEPTH];
    logic [7:0]        r_bs_q;
    logic [TB_W-1:0]   r_tb_q;

    logic              bs_we;
    logic [IDX_W-1:0]  bs_wa;
    logic [7:0]        bs_wd;
    logic [IDX_W-1:0]  bs_ra;
    logic              tb_we;
    logic [SLOT_W-1:0] tb_wa;
    logic [TB_W-1:0]   tb_wd;
    logic [SLOT_W-1:0] tb_ra;

    logic [CMP_W-1:0]  idx_in;
    logic [CMP_W-1:0]  tb_pos;
    logic [31:0]       tb_val;
    logic [CNT_W-1:0]  cur_next;
    logic [CNT_W-1:0]  mid;
    logic [CNT_W-1:0]  s_lo;
    logic [CNT_W-1:0]  s_hi;
    logic [CNT_W-1:0]  s_mid;
    logic [LEN_W-1:0]  lc_inc;

    ebas_cfg #(
        .ENTRIES (ENTRIES),
        .EL_W    (EL_W)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_eff_len (eff_len)
    );

    always_ff @(posedge i_clk) begin
        if (bs_we) begin
            byte_mem[bs_wa] <= bs_wd;
        end
        r_bs_q <= byte_mem[bs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tb_we) begin
            tb_mem[tb_wa] <= tb_wd;
        end
        r_tb_q <= tb_mem[tb_ra];
    end

    assign idx_in   = CMP_W'(i_read_index);
    assign tb_pos   = CMP_W'(r_tb_q[TB_W-1:32]);
    assign tb_val   = r_tb_q[31:0];
    assign cur_next = CNT_W'(r_cursor) + CNT_W'(1);
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign lc_inc   = r_lc + LEN_W'(1);
    assign s_lo     = (tb_pos < r_idx) ? mid + CNT_W'(1) : r_lo;
    assign s_hi     = (tb_pos < r_idx) ? r_hi : mid;
    assign s_mid    = s_lo + ((s_hi - s_lo) >> 1);

    always_comb begin
        n_state  = r_state;
        n_lc     = r_lc;
        n_cnt    = r_cnt;
        n_cursor = r_cursor;
        n_ready  = r_ready;
        n_idx    = r_idx;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_done   = 1'b0;
        n_data   = '0;
        n_status = ST_OK;
        bs_we    = 1'b0;
        bs_wa    = r_lc[IDX_W-1:0];
        bs_wd    = i_load_value[7:0];
        bs_ra    = idx_in[IDX_W-1:0];
        tb_we    = 1'b0;
        tb_wa    = r_cnt[SLOT_W-1:0];
        tb_wd    = {r_lc[IDX_W-1:0], i_load_value};
        tb_ra    = r_cursor;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_operation == OP_LOAD) begin
                        n_done = 1'b1;
                        if (r_ready || EL_W'(r_lc) >= eff_len) begin
                            n_ready  = 1'b1;
                            n_status = ST_DONE;
                        end else begin
                            bs_we = 1'b1;
                            if (i_load_value < 32'(ESCAPE_BYTE)) begin
                                bs_wd = i_load_value[7:0];
                            end else begin
                                bs_wd = ESCAPE_BYTE;
                                if (r_cnt < CNT_W'(OVERFLOW_DEPTH)) begin
                                    tb_we = 1'b1;
                                    n_cnt = r_cnt + CNT_W'(1);
                                end else begin
                                    n_status = ST_FULL;
                                end
                            end
                            n_lc = lc_inc;
                            if (EL_W'(lc_inc) >= eff_len) begin
                                n_ready = 1'b1;
                            end
                        end
                    end else if (32'(i_read_index) < 32'(ENTRIES)) begin
                        n_idx   = idx_in;
                        n_state = S_BYTE;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            S_BYTE: begin
                if (r_bs_q != ESCAPE_BYTE) begin
                    n_done  = 1'b1;
                    n_data  = 32'(r_bs_q);
                    n_state = S_IDLE;
                end else if (r_cnt == '0) begin
                    n_cursor = '0;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    if (cur_next >= r_cnt) begin
                        n_cursor = '0;
                    end else begin
                        n_cursor = cur_next[SLOT_W-1:0];
                    end
                    tb_ra   = n_cursor;
                    n_state = S_CURSOR;
                end
            end
            S_CURSOR: begin
                if (tb_pos == r_idx) begin
                    n_done  = 1'b1;
                    n_data  = tb_val;
                    n_state = S_IDLE;
                end else begin
                    n_lo    = '0;
                    n_hi    = r_cnt;
                    tb_ra   = SLOT_W'(r_cnt >> 1);
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_lo = s_lo;
                n_hi = s_hi;
                if (s_lo < s_hi) begin
                    tb_ra = s_mid[SLOT_W-1:0];
                end else if (s_lo >= r_cnt) begin
                    n_cursor = SLOT_W'(r_cnt - CNT_W'(1));
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_cursor = s_lo[SLOT_W-1:0];
                    tb_ra    = s_lo[SLOT_W-1:0];
                    n_state  = S_FINAL;
                end
            end
            S_FINAL: begin
                n_done  = 1'b1;
                n_data  = tb_val;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lc     <= '0;
            r_cnt    <= '0;
            r_cursor <= '0;
            r_ready  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lc     <= n_lc;
            r_cnt    <= n_cnt;
            r_cursor <= n_cursor;
            r_ready  <= n_ready;
            r_done   <= n_done;
        end
        r_idx    <= n_idx;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_data   <= n_data;
        r_status <= n_status;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_read_data = r_data;
    assign o_status    = r_status;
endmodule
`default_nettype wire

FILE: bench/tb_escaped_byte_array_store.sv
// Self-checking testbench that loads, reads and reconfigures the escaped byte array store.
`timescale 1ns / 1ps
module tb_escaped_byte_array_store;
    import ebas_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int BULK_FILL      = 400;
    localparam int REPORT_CAP     = 200;
    localparam logic [PADDR_W-1:0] LENGTH_ADDR = PADDR_W'(4 * int'(REG_ARRAY_LENGTH));

    typedef struct packed {
        logic [31:0] data;
        logic [1:0]  status;
    } t_result;

    typedef struct packed {
        logic        op;
        logic [15:0] idx;
        logic [31:0] val;
        logic        typed;
        t_result     res;
    } t_script_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_operation = OP_LOAD;
    logic [15:0]        i_read_index = '0;
    logic [31:0]        i_load_value = '0;
    logic               o_done;
    logic [31:0]        o_read_data;
    logic [1:0]         o_status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    escaped_byte_array_store dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_operation(i_operation),
        .i_read_index(i_read_index),
        .i_load_value(i_load_value),
        .o_done(o_done),
        .o_read_data(o_read_data),
        .o_status(o_status),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the store, kept in step with every accepted request.
    logic [7:0]      mirror_bytes [ENTRIES_DEF];
    logic [15:0]     mirror_pos [OVF_DEPTH_DEF];
    logic [31:0]     mirror_val [OVF_DEPTH_DEF];
    int              loaded = 0;
    int              slots_used = 0;
    int              cursor = 0;
    bit              complete = 1'b0;
    logic [AL_W-1:0] length_reg = AL_W'(AL_RESET);
    int              orphans [$];

    t_result pending_results [$];
    t_result oldest;
    int      mismatches = 0;
    int      quiet_cycles = 0;
    int      burst_left = 0;
    int      load_count = 0;
    int      read_count = 0;
    int      cursor_hits = 0;
    int      searches = 0;
    int      full_loads = 0;
    int      late_loads = 0;

    t_script_row opening_rows [0:16] = '{
        '{OP_LOAD, 16'hFFFF, 32'd0,           1'b1, '{32'd0, ST_OK}},
        '{OP_LOAD, 16'h8000, 32'd254,         1'b1, '{32'd0, ST_OK}},
        '{OP_LOAD, 16'h0000, 32'd255,         1'b1, '{32'd0, ST_OK}},
        '{OP_LOAD, 16'h7FFF, 32'd256,         1'b1, '{32'd0, ST_OK}},
        '{OP_LOAD, 16'h0001, 32'hFFFF_FFFF,   1'b1, '{32'd0, ST_OK}},
        '{OP_LOAD, 16'hFFFF, 32'd1,           1'b1, '{32'd0, ST_OK}},
        '{OP_LOAD, 16'h5555, 32'h8000_0000,   1'b1, '{32'd0, ST_OK}},
        '{OP_LOAD, 16'hAAAA, 32'h7FFF_FFFF,   1'b1, '{32'd0, ST_OK}},
        '{OP_READ, 16'd0,    32'hFFFF_FFFF,   1'b1, '{32'd0, ST_OK}},
        '{OP_READ, 16'd1,    32'h0000_0000,   1'b1, '{32'd254, ST_OK}},
        '{OP_READ, 16'd5,    32'hA5A5_A5A5,   1'b1, '{32'd1, ST_OK}},
        '{OP_READ, 16'd2,    32'h5A5A_5A5A,   1'b1, '{32'd255, ST_OK}},
        '{OP_READ, 16'd3,    32'hFFFF_FFFF,   1'b1, '{32'd256, ST_OK}},
        '{OP_READ, 16'd4,    32'h0000_0000,   1'b1, '{32'hFFFF_FFFF, ST_OK}},
        '{OP_READ, 16'd7,    32'h1234_5678,   1'b0, '{32'd0, ST_OK}},
        '{OP_READ, 16'd2,    32'h8765_4321,   1'b1, '{32'd255, ST_OK}},
        '{OP_READ, 16'd6,    32'hFFFF_FFFF,   1'b0, '{32'd0, ST_OK}}
    };

    function automatic logic [31:0] escaped_value(int idx);
        int next_slot;
        int lo;
        int hi;
        int mid;
        if (slots_used == 0) begin
            cursor = 0;
            return '0;
        end
        next_slot = cursor + 1;
        if (next_slot >= slots_used) next_slot = 0;
        cursor = next_slot;
        if (int'(mirror_pos[next_slot]) == idx) begin
            cursor_hits++;
            return mirror_val[next_slot];
        end
        searches++;
        lo = 0;
        hi = slots_used;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (int'(mirror_pos[mid]) < idx) lo = mid + 1;
            else hi = mid;
        end
        if (lo >= slots_used) begin
            cursor = slots_used - 1;
            return '0;
        end
        cursor = lo;
        return mirror_val[lo];
    endfunction

    function automatic t_result array_response(logic op, logic [15:0] idx, logic [31:0] val);
        t_result r;
        int      limit;
        r = '0;
        if (op == OP_LOAD) begin
            if (length_reg == '0) limit = 1;
            else if (int'(length_reg) > ENTRIES_DEF) limit = ENTRIES_DEF;
            else limit = int'(length_reg);
            if (complete || loaded >= limit) begin
                complete = 1'b1;
                r.status = ST_DONE;
                late_loads++;
            end else begin
                if (val < {24'b0, ESCAPE_BYTE}) begin
                    mirror_bytes[loaded] = val[7:0];
                end else begin
                    mirror_bytes[loaded] = ESCAPE_BYTE;
                    if (slots_used < OVF_DEPTH_DEF) begin
                        mirror_pos[slots_used] = 16'(loaded);
                        mirror_val[slots_used] = val;
                        slots_used++;
                    end else begin
                        r.status = ST_FULL;
                        orphans.push_back(loaded);
                        full_loads++;
                    end
                end
                loaded++;
                if (loaded >= limit) complete = 1'b1;
            end
        end else begin
            if (mirror_bytes[idx] != ESCAPE_BYTE) r.data = {24'b0, mirror_bytes[idx]};
            else r.data = escaped_value(int'(idx));
        end
        return r;
    endfunction

    function automatic logic [31:0] load_pick(int escape_pct);
        if ($urandom_range(0, 99) >= escape_pct) begin
            if ($urandom_range(0, 9) == 0) return 32'd254;
            return 32'($urandom_range(0, 254));
        end
        case ($urandom_range(0, 3))
            0: return 32'd255;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Only indexes that have already been loaded are ever read.
    function automatic logic [15:0] read_pick();
        int pick;
        int slot;
        pick = $urandom_range(0, 99);
        if (slots_used > 0 && pick < 30) begin
            slot = cursor + 1;
            if (slot >= slots_used) slot = 0;
            return mirror_pos[slot];
        end
        if (slots_used > 0 && pick < 55) return mirror_pos[$urandom_range(0, slots_used - 1)];
        if (orphans.size() > 0 && pick < 65)
            return 16'(orphans[$urandom_range(0, orphans.size() - 1)]);
        if (pick < 80) return 16'(loaded - 1 - $urandom_range(0, loaded > 16 ? 15 : loaded - 1));
        return 16'($urandom_range(0, loaded - 1));
    endfunction

    task automatic issue(logic op, logic [15:0] idx, logic [31:0] val, logic typed,
                         t_result typed_res);
        t_result predicted;
        start        <= 1'b1;
        i_operation  <= op;
        i_read_index <= idx;
        i_load_value <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = array_response(op, idx, val);
        pending_results.push_back(typed ? typed_res : predicted);
        if (op == OP_LOAD) load_count++;
        else read_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(60, 200);
            else burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic random_requests(int count, int load_pct, int escape_pct);
        repeat (count) begin
            if (loaded == 0 || $urandom_range(0, 99) < load_pct)
                issue(OP_LOAD, 16'($urandom), load_pick(escape_pct), 1'b0, '0);
            else
                issue(OP_READ, read_pick(), $urandom, 1'b0, '0);
        end
    endtask

    // Leaves psel high; the caller closes the last transfer.
    task automatic apb_transfer(logic write, logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= LENGTH_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
    endtask

    task automatic length_verify(logic [AL_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        apb_transfer(1'b0, '0, readback);
        if (readback !== PDATA_W'(value)) begin
            mismatches++;
            $display("%0t: array_length readback expected %h, got %h", $time,
                     PDATA_W'(value), readback);
        end
    endtask

    task automatic length_write(logic [AL_W-1:0] value);
        logic [PDATA_W-1:0] unused;
        apb_transfer(1'b1, PDATA_W'(value), unused);
        length_reg = value;
        length_verify(value);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: result with nothing expected, read_data %h status %0d",
                             $time, o_read_data, o_status);
            end else begin
                oldest = pending_results.pop_front();
                if (o_read_data !== oldest.data) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: read_data expected %h, got %h", $time,
                                 oldest.data, o_read_data);
                end
                if (o_status !== oldest.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: status expected %0d, got %0d", $time,
                                 oldest.status, o_status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result for %0d cycles", $time, quiet_cycles);
            $display("escaped_byte_array_store regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        length_verify(AL_W'(AL_RESET));
        length_write(AL_W'(1));
        length_write('0);
        length_write(AL_W'(AL_RESET));
        psel    <= 1'b0;
        penable <= 1'b0;

        foreach (opening_rows[i])
            issue(opening_rows[i].op, opening_rows[i].idx, opening_rows[i].val,
                  opening_rows[i].typed, opening_rows[i].res);

        random_requests(500, 55, 30);

        // Extend the store with a run of loads before the next mixed phase.
        while (loaded < BULK_FILL)
            issue(OP_LOAD, 16'($urandom), load_pick(15), 1'b0, '0);

        random_requests(500, 45, 30);

        settle();
        length_write(AL_W'(loaded + $urandom_range(40, 80)));
        psel    <= 1'b0;
        penable <= 1'b0;
        random_requests(100, 60, 30);

        settle();
        length_write('0);
        psel    <= 1'b0;
        penable <= 1'b0;
        random_requests(150, 50, 30);

        settle();
        length_write(AL_W'(AL_RESET));
        psel    <= 1'b0;
        penable <= 1'b0;
        random_requests(200, 50, 30);

        settle();
        $display("Covered %0d loads and %0d reads over %0d entries; %0d escaped reads hit",
                 load_count, read_count, loaded, cursor_hits);
        $display("the cursor, %0d searched; %0d loads met a full table, %0d a complete store.",
                 searches, full_loads, late_loads);
        if (mismatches == 0) begin
            $display("escaped_byte_array_store regression: pass");
        end else begin
            $display("escaped_byte_array_store regression: fail");
        end
        $finish;
    end
endmodule

FILE: sim.f
hdl/ebas_pkg.sv
hdl/ebas_cfg.sv
hdl/escaped_byte_array_store.sv
bench/tb_escaped_byte_array_store.sv
